### rtl/core/lkdd_pkg.sv
// Shared types, constants and decode functions for the ladder keypad decoder.
package lkdd_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int BOARD_LAYOUT  = 0;

  localparam int ADC_W        = 10;
  localparam int CMD_W        = 4;
  localparam int NUM_WIN_REGS = 8;
  localparam int SLOT_W       = $clog2(HISTORY_DEPTH);
  localparam int REG_IDX_W    = $clog2(NUM_WIN_REGS);
  localparam int ADDR_W       = REG_IDX_W + 2;
  localparam int DATA_W       = 32;

  typedef logic [ADC_W-1:0] adc_t;
  typedef logic [NUM_WIN_REGS-1:0][ADC_W-1:0] win_regs_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTHING   = 4'd0,
    CMD_POWER     = 4'd1,
    CMD_UP        = 4'd2,
    CMD_DOWN      = 4'd3,
    CMD_STROBE    = 4'd4,
    CMD_CROSSHAIR = 4'd5,
    CMD_EDID0     = 4'd6,
    CMD_EDID1     = 4'd7,
    CMD_EDID2     = 4'd8,
    CMD_EDID3     = 4'd9,
    CMD_EDID4     = 4'd10,
    CMD_UNDEF     = 4'd11
  } cmd_t;

  // Register order: win0_low, win0_high, win1_low, ... win3_high.
  localparam win_regs_t WIN_RESET = {
    10'd850, 10'd650, 10'd600, 10'd400, 10'd350, 10'd150, 10'd100, 10'd0
  };

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic scanning;
  } dp_cmd_t;

  typedef struct packed {
    logic last_idx;
    logic out_free;
  } dp_status_t;

  function automatic logic in_win(adc_t v, win_regs_t w, int unsigned n);
    return (v >= w[2*n]) && (v <= w[2*n+1]);
  endfunction

  function automatic cmd_t decode_single(adc_t a, logic pwr, win_regs_t w);
    logic [4:0] f;
    cmd_t       c;
    f = {pwr, in_win(a, w, 3), in_win(a, w, 2), in_win(a, w, 1), in_win(a, w, 0)};
    unique case (f)
      5'b10000: c = CMD_POWER;
      5'b10001: c = CMD_EDID0;
      5'b11000: c = CMD_EDID1;
      5'b10010: c = CMD_EDID2;
      5'b10100: c = CMD_EDID3;
      5'b00001: c = CMD_UP;
      5'b01000: c = CMD_STROBE;
      5'b00010: c = CMD_DOWN;
      5'b00100: c = CMD_CROSSHAIR;
      default:  c = CMD_NOTHING;
    endcase
    return c;
  endfunction

  function automatic cmd_t decode_dual(adc_t a, adc_t b, logic pwr, logic rev1,
                                       win_regs_t w);
    logic [2:0] f;
    cmd_t       c;
    f = {pwr, in_win(b, w, 0), in_win(a, w, 0)};
    unique case (f)
      3'b100:  c = CMD_POWER;
      3'b001:  c = CMD_UP;
      3'b010:  c = CMD_DOWN;
      default: c = CMD_NOTHING;
    endcase
    // The window matches below take priority in this order over the flags.
    priority if (in_win(a, w, 1)) c = CMD_EDID2;
    else if (in_win(a, w, 2)) c = CMD_EDID1;
    else if (in_win(a, w, 3)) c = CMD_EDID0;
    else if (in_win(b, w, 1)) c = CMD_STROBE;
    else if (in_win(b, w, 2)) c = rev1 ? CMD_EDID4 : CMD_CROSSHAIR;
    else if (in_win(b, w, 3)) c = CMD_EDID3;
    else c = c;
    return c;
  endfunction

  function automatic cmd_t decode(adc_t a, adc_t b, logic pwr, win_regs_t w);
    cmd_t c;
    if (BOARD_LAYOUT == 0) begin
      c = decode_single(a, pwr, w);
    end else begin
      c = decode_dual(a, b, pwr, BOARD_LAYOUT == 2, w);
    end
    return c;
  endfunction

endpackage

### rtl/core/lkdd_regs.sv
// APB register file holding the low and high bounds of the four ladder windows.
module lkdd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkdd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkdd_pkg::DATA_W-1:0]   pwdata,
  output logic [lkdd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lkdd_pkg::win_regs_t           win
);

  logic [lkdd_pkg::REG_IDX_W-1:0] idx;

  assign idx    = paddr[lkdd_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = lkdd_pkg::DATA_W'(win[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= lkdd_pkg::WIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      win[idx] <= pwdata[lkdd_pkg::ADC_W-1:0];
    end
  end

endmodule

### rtl/core/lkdd_ctrl.sv
// Controller that sequences accept, history scan and result hand-off.
module lkdd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lkdd_pkg::dp_status_t status,
  output lkdd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PEND = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step     = 1'b1;
        cmd.scanning = 1'b1;
        if (status.last_idx) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/lkdd_dp.sv
// Datapath: sample decode, history ring, match scan and result registers.
module lkdd_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lkdd_pkg::dp_cmd_t          cmd,
  output lkdd_pkg::dp_status_t       status,
  input  lkdd_pkg::win_regs_t        win,
  input  logic [lkdd_pkg::ADC_W-1:0] ladder_a,
  input  logic [lkdd_pkg::ADC_W-1:0] ladder_b,
  input  logic                       power_pressed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lkdd_pkg::CMD_W-1:0] filtered_cmd,
  output logic [lkdd_pkg::CMD_W-1:0] previous_cmd,
  output logic [lkdd_pkg::CMD_W-1:0] raw_cmd
);

  lkdd_pkg::cmd_t                hist [lkdd_pkg::HISTORY_DEPTH];
  logic [lkdd_pkg::SLOT_W-1:0]   slot, slot_next;
  logic [lkdd_pkg::SLOT_W-1:0]   idx;
  lkdd_pkg::cmd_t                code;
  lkdd_pkg::cmd_t                raw_next;
  lkdd_pkg::cmd_t                cur_filt, last_filt, filt_next;
  logic                          same_acc;
  logic                          eq;
  logic                          same_final;

  assign raw_next  = lkdd_pkg::decode(ladder_a, ladder_b, power_pressed, win);
  assign slot_next = (slot == lkdd_pkg::SLOT_W'(lkdd_pkg::HISTORY_DEPTH - 1)) ?
                     '0 : slot + 1'b1;

  // The new code sits in the ring, so all entries agree exactly when every
  // entry equals the new code.
  assign eq         = (hist[idx] == code);
  assign same_final = cmd.scanning ? (same_acc & eq) : same_acc;
  assign filt_next  = same_final ? code : lkdd_pkg::CMD_UNDEF;

  assign status.last_idx = (idx == lkdd_pkg::SLOT_W'(lkdd_pkg::HISTORY_DEPTH - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lkdd_pkg::HISTORY_DEPTH; i++) begin
        hist[i] <= lkdd_pkg::CMD_UNDEF;
      end
      slot      <= '0;
      cur_filt  <= lkdd_pkg::CMD_UNDEF;
      last_filt <= lkdd_pkg::CMD_UNDEF;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        hist[slot_next] <= raw_next;
        slot            <= slot_next;
      end
      if (cmd.finish) begin
        last_filt <= cur_filt;
        cur_filt  <= filt_next;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code     <= raw_next;
      idx      <= '0;
      same_acc <= 1'b1;
    end else if (cmd.step) begin
      same_acc <= same_acc & eq;
      idx      <= idx + 1'b1;
    end
    if (cmd.finish) begin
      filtered_cmd <= filt_next;
      previous_cmd <= cur_filt;
      raw_cmd      <= code;
    end
  end

endmodule

### rtl/core/ladder_keypad_decode_debounce.sv
// Top level of the ladder keypad decoder with history-based debounce.
// The scan compares one history entry per cycle against the new code, and a new item is
// accepted only after the result of the last one is written to the output registers.
// A result waiting in the output register does not block the next accept.
// Reset (synchronous, active high) restores the window bounds and fills the history with undefined.
module ladder_keypad_decode_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkdd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkdd_pkg::DATA_W-1:0]   pwdata,
  output logic [lkdd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lkdd_pkg::ADC_W-1:0]    ladder_a,
  input  logic [lkdd_pkg::ADC_W-1:0]    ladder_b,
  input  logic                          power_pressed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lkdd_pkg::CMD_W-1:0]    filtered_cmd,
  output logic [lkdd_pkg::CMD_W-1:0]    previous_cmd,
  output logic [lkdd_pkg::CMD_W-1:0]    raw_cmd
);

  lkdd_pkg::win_regs_t  win;
  lkdd_pkg::dp_cmd_t    cmd;
  lkdd_pkg::dp_status_t status;

  lkdd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .win     (win)
  );

  lkdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lkdd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .win           (win),
    .ladder_a      (ladder_a),
    .ladder_b      (ladder_b),
    .power_pressed (power_pressed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filtered_cmd  (filtered_cmd),
    .previous_cmd  (previous_cmd),
    .raw_cmd       (raw_cmd)
  );

endmodule

### rtl/core/lkdd_checker.sv
// Port-level checker for the ladder keypad decoder, bound to the top level.
module lkdd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lkdd_pkg::CMD_W-1:0]  filtered_cmd,
  input logic [lkdd_pkg::CMD_W-1:0]  raw_cmd
);

  // After reset the block is empty and ready for an item.
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // A defined filtered command can only be the code of the newest sample.
  a_filtered_matches_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && (filtered_cmd != lkdd_pkg::CMD_UNDEF) |-> filtered_cmd == raw_cmd)
    else $error("filtered command differs from raw command");

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_cmd) && $stable(raw_cmd))
    else $error("result changed while stalled");

endmodule

bind ladder_keypad_decode_debounce lkdd_checker u_lkdd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .filtered_cmd (filtered_cmd),
  .raw_cmd      (raw_cmd)
);
